// ----- design/tqaa_pkg.sv -----
// Shared types and codes for the two-queue admission arbiter.
package tqaa_pkg;

   localparam int ID_W    = 16;
   localparam int TIME_W  = 32;
   localparam int CTR_W   = 32;
   localparam int LIMIT_W = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   typedef enum logic [1:0] {
      OP_REQ_A   = 2'd0,
      OP_REQ_B   = 2'd1,
      OP_TICK    = 2'd2,
      OP_RELEASE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_ADMITTED = 3'd0,
      ST_REFUSED  = 3'd1,
      ST_BUSY     = 3'd2,
      ST_SERVED_A = 3'd3,
      ST_SERVED_B = 3'd4,
      ST_IDLE     = 3'd5,
      ST_RELEASED = 3'd6
   } status_type;

   localparam logic [CSR_IDX_W-1:0] CSR_ADMIT_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLASS_A    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CLASS_B    = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] arrival;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
   } q_ctrl_type;

endpackage

// ----- design/two_queue_admission_arbiter_top.sv -----
// Top level of the two-queue admission arbiter: channels, decision logic and counters.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_ready   op, requester_id, arrival_time, now
//   rsp_      out        rsp_valid/rsp_ready   status, served id/arrival, counts, totals
//   csr_      in         csr_wr_en             csr_index, csr_wr_data (no read-back)
//
// One item is taken every cycle while req_ready is high. An accepted item is
// held in the input register, is decided in a single pass against the queue
// heads, fill counts and counters, and its result is then loaded into the result
// register, which drives rsp_valid.
// A stalled result holds the pipeline: the input register keeps its item and
// req_ready drops only when both the input and the result register are full.
// Reset is synchronous and clears queue pointers, counters, flags and valids;
// the queue storage itself is not cleared and needs no sweep.
module two_queue_admission_arbiter_top
   import tqaa_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_op,
   input  logic [ID_W-1:0]       req_requester_id,
   input  logic [TIME_W-1:0]     req_arrival_time,
   input  logic [TIME_W-1:0]     req_now,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_status,
   output logic [ID_W-1:0]       rsp_served_id,
   output logic [TIME_W-1:0]     rsp_served_arrival,
   output logic [CNT_W-1:0]      rsp_count_a,
   output logic [CNT_W-1:0]      rsp_count_b,
   output logic [CTR_W-1:0]      rsp_served_total_a,
   output logic [CTR_W-1:0]      rsp_served_total_b,
   output logic [CTR_W-1:0]      rsp_refused_total_a,
   output logic [CTR_W-1:0]      rsp_refused_total_b,
   output logic [CTR_W-1:0]      rsp_wait_sum_a,
   output logic [CTR_W-1:0]      rsp_wait_sum_b,
   output logic [CTR_W-1:0]      rsp_idle_ticks,

   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   // Configuration registers.
   logic [LIMIT_W-1:0] admit_limit_ff;
   logic               class_a_flag_ff;
   logic               class_b_flag_ff;

   // Input register.
   logic               in_valid_ff, in_valid_in;
   op_type             op_ff;
   entry_type          req_entry_ff;
   logic [TIME_W-1:0]  now_ff;

   // Result register and state that the result reports directly.
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         status_ff, status_in;
   entry_type          served_ff, served_in;
   logic               occupied_ff, occupied_in;
   logic [TIME_W-1:0]  idle_stamp_ff, idle_stamp_in;
   logic               stamp_valid_ff, stamp_valid_in;
   logic [CTR_W-1:0]   served_a_ff, served_a_in;
   logic [CTR_W-1:0]   served_b_ff, served_b_in;
   logic [CTR_W-1:0]   refused_a_ff, refused_a_in;
   logic [CTR_W-1:0]   refused_b_ff, refused_b_in;
   logic [CTR_W-1:0]   wait_a_ff, wait_a_in;
   logic [CTR_W-1:0]   wait_b_ff, wait_b_in;
   logic [CTR_W-1:0]   idle_ff, idle_in;

   // Queue interface.
   q_ctrl_type         ctrl_a, ctrl_b;
   logic [CNT_W-1:0]   fill_a, fill_b;
   entry_type          head_a, head_b;

   logic               advance;
   logic               proc;
   logic               a_empty, b_empty;
   logic               room_a, room_b;
   logic [TIME_W-1:0]  wait_delta;

   // The result register can take a new result when it is empty or being drained.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign proc      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (proc) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (proc) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // A queue admits while below both the programmed limit and its physical depth.
   assign a_empty = (fill_a == '0);
   assign b_empty = (fill_b == '0);
   assign room_a  = (CMP_W'(fill_a) < CMP_W'(admit_limit_ff)) &&
                    (fill_a < CNT_W'(QUEUE_DEPTH));
   assign room_b  = (CMP_W'(fill_b) < CMP_W'(admit_limit_ff)) &&
                    (fill_b < CNT_W'(QUEUE_DEPTH));

   // Single-pass decision for the item in the input register.
   always_comb begin
      status_in      = status_ff;
      served_in      = served_ff;
      occupied_in    = occupied_ff;
      idle_stamp_in  = idle_stamp_ff;
      stamp_valid_in = stamp_valid_ff;
      served_a_in    = served_a_ff;
      served_b_in    = served_b_ff;
      refused_a_in   = refused_a_ff;
      refused_b_in   = refused_b_ff;
      wait_a_in      = wait_a_ff;
      wait_b_in      = wait_b_ff;
      idle_in        = idle_ff;
      ctrl_a         = '0;
      ctrl_b         = '0;
      wait_delta     = '0;

      if (proc) begin
         served_in = '0;
         case (op_ff)
            OP_REQ_A: begin
               if (room_a) begin
                  ctrl_a.push = 1'b1;
                  status_in   = ST_ADMITTED;
               end else begin
                  refused_a_in = refused_a_ff + CTR_W'(1);
                  status_in    = ST_REFUSED;
               end
            end
            OP_REQ_B: begin
               if (room_b) begin
                  ctrl_b.push = 1'b1;
                  status_in   = ST_ADMITTED;
               end else begin
                  refused_b_in = refused_b_ff + CTR_W'(1);
                  status_in    = ST_REFUSED;
               end
            end
            OP_TICK: begin
               // Each class is held back while the other is empty and the other class's flag is set.
               if (occupied_ff) begin
                  status_in = ST_BUSY;
               end else if (!a_empty && !(b_empty && class_b_flag_ff)) begin
                  ctrl_a.pop  = 1'b1;
                  served_in   = head_a;
                  wait_delta  = now_ff - head_a.arrival;
                  wait_a_in   = wait_a_ff + wait_delta;
                  served_a_in = served_a_ff + CTR_W'(1);
                  occupied_in = 1'b1;
                  status_in   = ST_SERVED_A;
               end else if (!b_empty && !(a_empty && class_a_flag_ff)) begin
                  ctrl_b.pop  = 1'b1;
                  served_in   = head_b;
                  wait_delta  = now_ff - head_b.arrival;
                  wait_b_in   = wait_b_ff + wait_delta;
                  served_b_in = served_b_ff + CTR_W'(1);
                  occupied_in = 1'b1;
                  status_in   = ST_SERVED_B;
               end else begin
                  status_in = ST_IDLE;
                  // Repeated idle ticks at the same time count only once.
                  if (!stamp_valid_ff || (idle_stamp_ff != now_ff)) begin
                     idle_in        = idle_ff + CTR_W'(1);
                     idle_stamp_in  = now_ff;
                     stamp_valid_in = 1'b1;
                  end
               end
            end
            OP_RELEASE: begin
               occupied_in = 1'b0;
               status_in   = ST_RELEASED;
            end
            default: begin
               status_in = ST_RELEASED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         admit_limit_ff  <= '0;
         class_a_flag_ff <= 1'b0;
         class_b_flag_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ADMIT_LIMIT: admit_limit_ff  <= csr_wr_data[LIMIT_W-1:0];
            CSR_CLASS_A:     class_a_flag_ff <= csr_wr_data[0];
            CSR_CLASS_B:     class_b_flag_ff <= csr_wr_data[0];
            default: begin
               admit_limit_ff <= admit_limit_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         occupied_ff    <= 1'b0;
         idle_stamp_ff  <= '0;
         stamp_valid_ff <= 1'b0;
         served_a_ff    <= '0;
         served_b_ff    <= '0;
         refused_a_ff   <= '0;
         refused_b_ff   <= '0;
         wait_a_ff      <= '0;
         wait_b_ff      <= '0;
         idle_ff        <= '0;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         occupied_ff    <= occupied_in;
         idle_stamp_ff  <= idle_stamp_in;
         stamp_valid_ff <= stamp_valid_in;
         served_a_ff    <= served_a_in;
         served_b_ff    <= served_b_in;
         refused_a_ff   <= refused_a_in;
         refused_b_ff   <= refused_b_in;
         wait_a_ff      <= wait_a_in;
         wait_b_ff      <= wait_b_in;
         idle_ff        <= idle_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff                <= op_type'(req_op);
         req_entry_ff.id      <= req_requester_id;
         req_entry_ff.arrival <= req_arrival_time;
         now_ff               <= req_now;
      end
      status_ff <= status_in;
      served_ff <= served_in;
   end

   tqaa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_a (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl_a),
      .push_entry (req_entry_ff),
      .fill       (fill_a),
      .head_entry (head_a)
   );

   tqaa_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_b (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl_b),
      .push_entry (req_entry_ff),
      .fill       (fill_b),
      .head_entry (head_b)
   );

   // Counters and fill counts change only when a result is loaded, so they
   // always match the result held in the result register.
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_served_id       = served_ff.id;
   assign rsp_served_arrival  = served_ff.arrival;
   assign rsp_count_a         = fill_a;
   assign rsp_count_b         = fill_b;
   assign rsp_served_total_a  = served_a_ff;
   assign rsp_served_total_b  = served_b_ff;
   assign rsp_refused_total_a = refused_a_ff;
   assign rsp_refused_total_b = refused_b_ff;
   assign rsp_wait_sum_a      = wait_a_ff;
   assign rsp_wait_sum_b      = wait_b_ff;
   assign rsp_idle_ticks      = idle_ff;

endmodule

// ----- design/tqaa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tqaa_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/tqaa_queue.sv -----
// Circular FIFO of requester entries with head pointer, fill count and head forwarding.
module tqaa_queue
   import tqaa_pkg::*;
#(
   parameter int DEPTH = 16,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  q_ctrl_type       ctrl,
   input  entry_type        push_entry,
   output logic [CNT_W-1:0] fill,
   output entry_type        head_entry
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SUM_W = CNT_W + 1;

   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             fwd_ff, fwd_in;
   entry_type        fwd_entry_ff;
   logic [SUM_W-1:0] tail_sum;
   logic [SUM_W-1:0] tail_wrap;
   logic [IDX_W-1:0] tail;
   logic [$bits(entry_type)-1:0] rd_data;

   // Tail slot is head plus fill, folded back once into the ring.
   always_comb begin
      tail_sum  = SUM_W'(head_ff) + SUM_W'(fill_ff);
      tail_wrap = (tail_sum >= SUM_W'(DEPTH)) ? (tail_sum - SUM_W'(DEPTH)) : tail_sum;
      tail      = tail_wrap[IDX_W-1:0];
   end

   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      if (ctrl.pop) begin
         head_in = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
         fill_in = fill_ff - CNT_W'(1);
      end else if (ctrl.push) begin
         fill_in = fill_ff + CNT_W'(1);
      end
      // A write into the slot being read this cycle is forwarded around the RAM.
      fwd_in = ctrl.push && (tail == head_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
         fwd_ff  <= 1'b0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
         fwd_ff  <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_entry_ff <= push_entry;
   end

   tqaa_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ctrl.push),
      .wr_addr (tail),
      .wr_data (push_entry),
      .rd_addr (head_in),
      .rd_data (rd_data)
   );

   assign fill       = fill_ff;
   assign head_entry = fwd_ff ? fwd_entry_ff : entry_type'(rd_data);

endmodule

// ----- bench/admission_checker.sv -----
// Scoreboard for the two-queue admission arbiter: predicts every result and compares it.
module admission_checker
   import tqaa_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [1:0]            req_op,
   input  logic [ID_W-1:0]       req_requester_id,
   input  logic [TIME_W-1:0]     req_arrival_time,
   input  logic [TIME_W-1:0]     req_now,

   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [2:0]            rsp_status,
   input  logic [ID_W-1:0]       rsp_served_id,
   input  logic [TIME_W-1:0]     rsp_served_arrival,
   input  logic [CNT_W-1:0]      rsp_count_a,
   input  logic [CNT_W-1:0]      rsp_count_b,
   input  logic [CTR_W-1:0]      rsp_served_total_a,
   input  logic [CTR_W-1:0]      rsp_served_total_b,
   input  logic [CTR_W-1:0]      rsp_refused_total_a,
   input  logic [CTR_W-1:0]      rsp_refused_total_b,
   input  logic [CTR_W-1:0]      rsp_wait_sum_a,
   input  logic [CTR_W-1:0]      rsp_wait_sum_b,
   input  logic [CTR_W-1:0]      rsp_idle_ticks,

   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,

   output int                    failures,
   output int                    pending_results
);

   typedef struct {
      status_type        status;
      logic [ID_W-1:0]   served_id;
      logic [TIME_W-1:0] served_arrival;
      logic [CNT_W-1:0]  count_a;
      logic [CNT_W-1:0]  count_b;
      logic [CTR_W-1:0]  served_a;
      logic [CTR_W-1:0]  served_b;
      logic [CTR_W-1:0]  refused_a;
      logic [CTR_W-1:0]  refused_b;
      logic [CTR_W-1:0]  wait_a;
      logic [CTR_W-1:0]  wait_b;
      logic [CTR_W-1:0]  idle_ticks;
   } outcome_type;

   outcome_type       expected_outcomes[$];
   entry_type         line_a[$];
   entry_type         line_b[$];
   logic              resource_busy;
   logic              stamp_set;
   logic [TIME_W-1:0] idle_stamp;
   logic [CTR_W-1:0]  served_a, served_b, refused_a, refused_b;
   logic [CTR_W-1:0]  wait_a, wait_b, idle_ticks;
   logic [LIMIT_W-1:0] limit_cfg;
   logic              prio_a, prio_b;
   int                errors = 0;

   // Applies one item to the shadow queues and counters and returns the outcome.
   function automatic outcome_type arbitrate(op_type op, logic [ID_W-1:0] id,
                                             logic [TIME_W-1:0] arrival,
                                             logic [TIME_W-1:0] stamp);
      outcome_type r;
      entry_type   head;
      logic        a_empty, b_empty;
      r.served_id      = '0;
      r.served_arrival = '0;
      a_empty = (line_a.size() == 0);
      b_empty = (line_b.size() == 0);
      case (op)
         OP_REQ_A: begin
            if (line_a.size() < limit_cfg && line_a.size() < QUEUE_DEPTH) begin
               line_a.push_back('{id, arrival});
               r.status = ST_ADMITTED;
            end else begin
               refused_a += 1;
               r.status = ST_REFUSED;
            end
         end
         OP_REQ_B: begin
            if (line_b.size() < limit_cfg && line_b.size() < QUEUE_DEPTH) begin
               line_b.push_back('{id, arrival});
               r.status = ST_ADMITTED;
            end else begin
               refused_b += 1;
               r.status = ST_REFUSED;
            end
         end
         OP_TICK: begin
            if (resource_busy) begin
               r.status = ST_BUSY;
            end else if (!a_empty && !(b_empty && prio_b)) begin
               head = line_a.pop_front();
               wait_a += stamp - head.arrival;
               served_a += 1;
               resource_busy = 1'b1;
               r.status = ST_SERVED_A;
               r.served_id = head.id;
               r.served_arrival = head.arrival;
            end else if (!b_empty && !(a_empty && prio_a)) begin
               head = line_b.pop_front();
               wait_b += stamp - head.arrival;
               served_b += 1;
               resource_busy = 1'b1;
               r.status = ST_SERVED_B;
               r.served_id = head.id;
               r.served_arrival = head.arrival;
            end else begin
               r.status = ST_IDLE;
               // Repeated idle ticks at one time value count only once.
               if (!stamp_set || idle_stamp != stamp) begin
                  idle_ticks += 1;
                  idle_stamp = stamp;
                  stamp_set = 1'b1;
               end
            end
         end
         default: begin
            resource_busy = 1'b0;
            r.status = ST_RELEASED;
         end
      endcase
      r.count_a    = CNT_W'(line_a.size());
      r.count_b    = CNT_W'(line_b.size());
      r.served_a   = served_a;
      r.served_b   = served_b;
      r.refused_a  = refused_a;
      r.refused_b  = refused_b;
      r.wait_a     = wait_a;
      r.wait_b     = wait_b;
      r.idle_ticks = idle_ticks;
      return r;
   endfunction

   task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         if (errors < 10)
            $display("mismatch in %s: expected 0x%0h, got 0x%0h", field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : track
      outcome_type want;
      if (reset) begin
         expected_outcomes.delete();
         line_a.delete();
         line_b.delete();
         resource_busy = 1'b0;
         stamp_set = 1'b0;
         idle_stamp = '0;
         served_a = '0;
         served_b = '0;
         refused_a = '0;
         refused_b = '0;
         wait_a = '0;
         wait_b = '0;
         idle_ticks = '0;
         limit_cfg = '0;
         prio_a = 1'b0;
         prio_b = 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ADMIT_LIMIT: limit_cfg = csr_wr_data[LIMIT_W-1:0];
               CSR_CLASS_A: prio_a = csr_wr_data[0];
               CSR_CLASS_B: prio_b = csr_wr_data[0];
               default: ;
            endcase
         end
         // A result taken at this edge always belongs to an item taken earlier.
         if (rsp_valid && rsp_ready) begin
            if (expected_outcomes.size() == 0) begin
               if (errors < 10)
                  $display("unexpected result with status %0d", rsp_status);
               errors++;
            end else begin
               want = expected_outcomes.pop_front();
               check_field("status", 32'(rsp_status), 32'(want.status));
               check_field("served_id", 32'(rsp_served_id), 32'(want.served_id));
               check_field("served_arrival", rsp_served_arrival, want.served_arrival);
               check_field("count_a", 32'(rsp_count_a), 32'(want.count_a));
               check_field("count_b", 32'(rsp_count_b), 32'(want.count_b));
               check_field("served_total_a", rsp_served_total_a, want.served_a);
               check_field("served_total_b", rsp_served_total_b, want.served_b);
               check_field("refused_total_a", rsp_refused_total_a, want.refused_a);
               check_field("refused_total_b", rsp_refused_total_b, want.refused_b);
               check_field("wait_sum_a", rsp_wait_sum_a, want.wait_a);
               check_field("wait_sum_b", rsp_wait_sum_b, want.wait_b);
               check_field("idle_ticks", rsp_idle_ticks, want.idle_ticks);
            end
         end
         if (req_valid && req_ready)
            expected_outcomes.push_back(arbitrate(op_type'(req_op), req_requester_id,
                                                  req_arrival_time, req_now));
      end
      failures <= errors;
      pending_results <= expected_outcomes.size();
   end

endmodule

// ----- bench/two_queue_admission_arbiter_top_tb.sv -----
// Testbench top for the two-queue admission arbiter: stimulus, flow control and verdict.
module two_queue_admission_arbiter_top_tb;
   import tqaa_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   // Cycles without any handshake before the run is declared hung. A correct run
   // never gets near this: the longest quiet stretch is a few stalls plus the
   // pipeline latency and a short register update.
   localparam int QUIET_LIMIT = 1000;
   localparam int PHASES      = 8;
   // Index 3 maps to no register; writes to it must leave the block untouched.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_op = OP_REQ_A;
   logic [ID_W-1:0]       req_requester_id = '0;
   logic [TIME_W-1:0]     req_arrival_time = '0;
   logic [TIME_W-1:0]     req_now = '0;

   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [2:0]            rsp_status;
   logic [ID_W-1:0]       rsp_served_id;
   logic [TIME_W-1:0]     rsp_served_arrival;
   logic [CNT_W-1:0]      rsp_count_a;
   logic [CNT_W-1:0]      rsp_count_b;
   logic [CTR_W-1:0]      rsp_served_total_a;
   logic [CTR_W-1:0]      rsp_served_total_b;
   logic [CTR_W-1:0]      rsp_refused_total_a;
   logic [CTR_W-1:0]      rsp_refused_total_b;
   logic [CTR_W-1:0]      rsp_wait_sum_a;
   logic [CTR_W-1:0]      rsp_wait_sum_b;
   logic [CTR_W-1:0]      rsp_idle_ticks;

   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_ADMIT_LIMIT;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   int                    failures;
   int                    pending_results;

   // When set, neither side inserts gaps, so the block runs at full rate.
   logic                  steady = 1'b0;
   // Running time base for service ticks; it starts just below the wrap point
   // so that the wait sums see time roll over.
   logic [TIME_W-1:0]     tick_stamp = 32'hFFFF_FFC0;
   int                    quiet_cycles = 0;

   // Per-phase register settings. Together they reach every flag combination,
   // a limit of zero, a limit of one, the queue depth and a limit above it.
   // The last phase draws its settings at random.
   int phase_limit[PHASES] = '{16, 1, 31, 3, 0, 16, 8, 0};
   int phase_prio_a[PHASES] = '{0, 1, 0, 1, 1, 0, 1, 0};
   int phase_prio_b[PHASES] = '{0, 0, 1, 1, 0, 1, 1, 0};
   int phase_req_pct[PHASES] = '{50, 40, 70, 50, 50, 45, 55, 50};
   int phase_items[PHASES] = '{50, 50, 50, 50, 20, 50, 50, 50};

   two_queue_admission_arbiter_top #(.QUEUE_DEPTH(QUEUE_DEPTH)) uut (.*);

   admission_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: any cycle that moves an item on either channel resets the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Result side: before each result the receiver holds ready low for a random
   // stall, none when steady, then keeps it high until a result is taken.
   initial begin : result_sink
      int stall;
      forever begin
         stall = steady ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Presents one item after a random gap and returns at the edge that takes it.
   // Valid is only lowered when there is a gap, so a back-to-back item never sees
   // valid dropped and raised in the same step.
   task automatic send_item(op_type op, logic [ID_W-1:0] id,
                            logic [TIME_W-1:0] arrival, logic [TIME_W-1:0] stamp);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= op;
      req_requester_id <= id;
      req_arrival_time <= arrival;
      req_now          <= stamp;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stops sending and waits until every result in flight has been taken. The
   // first edge lets the checker's count take in the item accepted last.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   // Writes all three registers, plus the unused index with random data. The
   // flag writes carry random upper bits, which the block must ignore.
   task automatic program_arbiter(logic [LIMIT_W-1:0] limit, logic prio_a, logic prio_b);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_ADMIT_LIMIT;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_index   <= CSR_CLASS_A;
      csr_wr_data <= {4'($urandom), prio_a};
      @(posedge clock);
      csr_index   <= CSR_CLASS_B;
      csr_wr_data <= {4'($urandom), prio_b};
      @(posedge clock);
      csr_index   <= CSR_SPARE;
      csr_wr_data <= CSR_DATA_W'($urandom);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin : stimulus
      op_type            op;
      int                pick;
      int                stamp_pick;
      logic [LIMIT_W-1:0] limit;
      logic              prio_a, prio_b;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] stamp;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Registers still hold their reset values, so the limit is zero and both
      // requests are refused. The first idle tick counts even at time zero,
      // since no idle time is recorded yet; a second tick at the same time does
      // not. A release with the resource already free just reports released.
      send_item(OP_REQ_A, 16'hFFFF, 32'hFFFF_FFFF, 32'h0);
      send_item(OP_REQ_B, 16'h0000, 32'h0, 32'hFFFF_FFFF);
      send_item(OP_TICK, 16'h0, 32'h0, 32'h0);
      send_item(OP_TICK, 16'hFFFF, 32'hFFFF_FFFF, 32'h0);
      send_item(OP_RELEASE, 16'h0, 32'h0, 32'h0);
      wait_for_results();

      // With a limit above the queue depth, the seventeenth class A request is
      // refused by the depth alone. The first entry carries the largest id and
      // arrival time, so its wait wraps around zero when it is served.
      program_arbiter(5'd31, 1'b0, 1'b0);
      for (int k = 0; k < QUEUE_DEPTH + 1; k++)
         send_item(OP_REQ_A, (k == 0) ? 16'hFFFF : 16'(k),
                   (k == 0) ? 32'hFFFF_FFFF : 32'(k * 3), 32'h0);
      send_item(OP_REQ_B, 16'h0, 32'h0, 32'h0);
      send_item(OP_TICK, 16'h0, 32'h0, 32'd5);
      send_item(OP_TICK, 16'h0, 32'h0, 32'd6);
      send_item(OP_RELEASE, 16'h0, 32'h0, 32'h0);
      send_item(OP_TICK, 16'h0, 32'h0, 32'hFFFF_FFFF);

      // Random phases. Each one starts from an idle block, so every register
      // write lands between items, and the sender has paused until all results
      // are back. Two phases run without gaps on either side.
      for (int p = 0; p < PHASES; p++) begin
         wait_for_results();
         if (p == PHASES - 1) begin
            limit  = LIMIT_W'($urandom_range(0, 31));
            prio_a = 1'($urandom);
            prio_b = 1'($urandom);
         end else begin
            limit  = LIMIT_W'(phase_limit[p]);
            prio_a = 1'(phase_prio_a[p]);
            prio_b = 1'(phase_prio_b[p]);
         end
         program_arbiter(limit, prio_a, prio_b);
         steady = (p == 2 || p == 5);

         for (int i = 0; i < phase_items[p]; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < phase_req_pct[p])
               op = ($urandom_range(0, 1) != 0) ? OP_REQ_B : OP_REQ_A;
            else if (pick < 90)
               op = OP_TICK;
            else
               op = OP_RELEASE;

            // Ticks mostly move time forward a little, sometimes repeat the
            // last time (to exercise the idle de-duplication) and sometimes
            // jump anywhere in the 32-bit range.
            if (op == OP_TICK) begin
               stamp_pick = $urandom_range(0, 9);
               if (stamp_pick >= 8)
                  tick_stamp = $urandom;
               else if (stamp_pick >= 3)
                  tick_stamp = tick_stamp + $urandom_range(1, 40);
               stamp = tick_stamp;
            end else begin
               stamp = $urandom;
            end

            // Arrivals are usually a little behind the current time, so wait
            // sums stay meaningful, with some fully random ones mixed in.
            if ($urandom_range(0, 9) < 7)
               arrival = tick_stamp - $urandom_range(0, 100);
            else
               arrival = $urandom;

            send_item(op, ID_W'($urandom), arrival, stamp);
         end
      end

      // Drain, then give the pipeline a few more edges so that a stray extra result
      // would still be seen before the verdict.
      wait_for_results();
      repeat (4) @(posedge clock);
      if (failures == 0 && pending_results == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ----- sim.f -----
design/tqaa_pkg.sv
design/tqaa_ram.sv
design/tqaa_queue.sv
design/two_queue_admission_arbiter_top.sv
bench/admission_checker.sv
bench/two_queue_admission_arbiter_top_tb.sv
